/* rtl/efp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package efp_pkg;

   // Field and register widths
   localparam int PIXEL_W   = 10;
   localparam int COORD_W   = 32;
   localparam int STEP_W    = 31;
   localparam int COUNT_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Datapath widths
   localparam int LIMB_W = 32;                 // shared multiplier operand width
   localparam int PXS_W  = PIXEL_W + STEP_W;   // pixel index times step
   localparam int C_W    = PXS_W + 2;          // point c, signed
   localparam int Z_W    = 64;                 // iterate z, signed

   // Parameter defaults
   localparam int FRAME_WIDTH_DEF  = 1024;
   localparam int FRAME_HEIGHT_DEF = 1024;
   localparam int FRAC_BITS_DEF    = 28;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_REAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_IMAG = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_REAL   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_IMAG   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER    = 3'd4;

   // Register reset values
   localparam logic [COORD_W-1:0] ORIGIN_REAL_RST = 32'hE000_0000;
   localparam logic [COORD_W-1:0] ORIGIN_IMAG_RST = 32'hF000_0000;
   localparam logic [STEP_W-1:0]  STEP_REAL_RST   = 31'd786432;
   localparam logic [STEP_W-1:0]  STEP_IMAG_RST   = 31'd524288;
   localparam logic [COUNT_W-1:0] MAX_ITER_RST    = 16'd256;

   // Which product the shared multiplier is building
   typedef logic [1:0] prod_sel_type;
   localparam prod_sel_type PROD_RR = 2'd0;   // zr * zr
   localparam prod_sel_type PROD_II = 2'd1;   // zi * zi
   localparam prod_sel_type PROD_RI = 2'd2;   // zr * zi

endpackage

`default_nettype wire

/* rtl/escape_time_fractal_pixel_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Escape-time fractal pixel core.
// Request channel (req_valid/req_ready) carries one pixel (column, row). The pixel
// is clamped to the frame, mapped to c = origin + index * step (signed fixed point,
// FRAC_BITS fraction bits) and z = z*z + c is iterated from zero while |z|^2 <= 4
// and the count is below max_iterations. The response channel (rsp_valid/rsp_ready)
// returns the iteration count and an inside flag (count reached the limit).
// Configuration is written through csr_write_en/csr_index/csr_wdata; the user must
// write it only while no request is in flight, which the block does not enforce.
// Timing: one request at a time; req_ready is high only between requests. All
// multiplications run on one shared 32x32 multiplier, P = ceil((FRAC_BITS+2)/32)^2
// partial products per square or cross term. Setup passes ST_CR, ST_CI and ST_CINIT;
// each iteration passes ST_CHECK, ST_MUL (all partial products of zr*zr, zi*zi and
// zr*zi), ST_WAIT and ST_EVAL; ST_OUT then hands the result to the output register,
// waiting while that register still holds a response the receiver has not taken.
// A finished response waits in the output register while the receiver stalls;
// the next request is accepted as soon as that register has been loaded.
// Reset (synchronous, active high) restores the register defaults, drops any
// request in flight and clears the response valid.

module escape_time_fractal_pixel_core
   import efp_pkg::*;
#(
   parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF,
   parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  wire  [PIXEL_W-1:0]      req_pixel_x,
   input  wire  [PIXEL_W-1:0]      req_pixel_y,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output logic [COUNT_W-1:0]      rsp_iteration_count,
   output logic                    rsp_inside_set,
   input  wire                     csr_write_en,
   input  wire  [CSR_IDX_W-1:0]    csr_index,
   input  wire  [CSR_DAT_W-1:0]    csr_wdata
);

   // Operand and accumulator sizing follows the fraction width
   localparam int OP_BITS = FRAC_BITS + 2;                 // |zr|, |zi| <= 2 before a step
   localparam int NLIMB   = (OP_BITS + LIMB_W - 1) / LIMB_W;
   localparam int OPW     = NLIMB * LIMB_W;
   localparam int ACC_W   = 2 * OPW;
   localparam int PAIRS   = NLIMB * NLIMB;
   localparam int PAIR_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
   localparam int LIDX_W  = (NLIMB > 1) ? $clog2(NLIMB) : 1;
   localparam int SH_W    = (NLIMB > 1) ? $clog2(2 * NLIMB - 1) : 1;
   localparam int PIX_CMP_W = 13;

   localparam logic [Z_W-1:0]   EDGE  = Z_W'(2) << FRAC_BITS;
   localparam logic [ACC_W:0]   LIMIT = (ACC_W + 1)'(1) << (2 * FRAC_BITS + 2);
   localparam logic [PIXEL_W-1:0] X_LAST = PIXEL_W'(FRAME_WIDTH - 1);
   localparam logic [PIXEL_W-1:0] Y_LAST = PIXEL_W'(FRAME_HEIGHT - 1);

   // Sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CR    = 4'd1;   // px * step_real
   localparam logic [3:0] ST_CI    = 4'd2;   // form cr, py * step_imag
   localparam logic [3:0] ST_CINIT = 4'd3;   // form ci, clear z and count
   localparam logic [3:0] ST_CHECK = 4'd4;   // limit and magnitude bound
   localparam logic [3:0] ST_MUL   = 4'd5;   // issue partial products
   localparam logic [3:0] ST_WAIT  = 4'd6;   // drain last partial product
   localparam logic [3:0] ST_EVAL  = 4'd7;   // exact |z|^2 test, step z
   localparam logic [3:0] ST_OUT   = 4'd8;   // hand result to output register

   // Configuration registers
   logic [COORD_W-1:0] origin_real_ff, origin_imag_ff;
   logic [STEP_W-1:0]  step_real_ff, step_imag_ff;
   logic [COUNT_W-1:0] max_iter_ff;

   // Sequencer and datapath registers
   logic [3:0]          state_ff, state_in;
   logic [PIXEL_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [C_W-1:0]      cr_ff, cr_in, ci_ff, ci_in;
   logic [Z_W-1:0]      zr_ff, zr_in, zi_ff, zi_in;
   logic [COUNT_W-1:0]  n_ff, n_in;
   logic [OPW-1:0]      ar_ff, ar_in, ai_ff, ai_in;
   logic [ACC_W-1:0]    sr_ff, sr_in, si_ff, si_in, xp_ff, xp_in;
   logic [PAIR_W-1:0]   pair_ff, pair_in;
   prod_sel_type        psel_ff, psel_in;
   logic [2*LIMB_W-1:0] prod_ff;
   logic                prod_vld_ff, prod_vld_in;
   prod_sel_type        prod_tag_ff, prod_tag_in;
   logic [SH_W-1:0]     prod_sh_ff, prod_sh_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_inside_ff, rsp_inside_in;

   // Shared multiplier
   logic [LIMB_W-1:0]   mul_a, mul_b;
   logic [2*LIMB_W-1:0] mul_p;
   logic [LIDX_W-1:0]   lim_i, lim_j;

   // Iteration arithmetic
   logic [Z_W-1:0]   mag_r, mag_i;
   logic [ACC_W:0]   mag_sum;
   logic [ACC_W-1:0] sr_shift, si_shift, xp_shift;
   logic [Z_W-1:0]   cross_term, cr_ext, ci_ext, nr, ni;
   logic [ACC_W-1:0] part_shifted;
   logic             req_fire;

   assign req_ready           = (state_ff == ST_IDLE);
   assign req_fire            = req_valid && req_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign rsp_inside_set      = rsp_inside_ff;

   // Limb indexes of the current partial product
   assign lim_i = LIDX_W'(pair_ff / NLIMB);
   assign lim_j = LIDX_W'(pair_ff % NLIMB);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_CR: begin
            mul_a = LIMB_W'(px_ff);
            mul_b = LIMB_W'(step_real_ff);
         end
         ST_CI: begin
            mul_a = LIMB_W'(py_ff);
            mul_b = LIMB_W'(step_imag_ff);
         end
         ST_MUL: begin
            unique case (psel_ff)
               PROD_RR: begin
                  mul_a = ar_ff[LIMB_W*lim_i +: LIMB_W];
                  mul_b = ar_ff[LIMB_W*lim_j +: LIMB_W];
               end
               PROD_II: begin
                  mul_a = ai_ff[LIMB_W*lim_i +: LIMB_W];
                  mul_b = ai_ff[LIMB_W*lim_j +: LIMB_W];
               end
               default: begin
                  mul_a = ar_ff[LIMB_W*lim_i +: LIMB_W];
                  mul_b = ai_ff[LIMB_W*lim_j +: LIMB_W];
               end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Magnitudes, exact bound and next z
   assign mag_r    = zr_ff[Z_W-1] ? (Z_W'(0) - zr_ff) : zr_ff;
   assign mag_i    = zi_ff[Z_W-1] ? (Z_W'(0) - zi_ff) : zi_ff;
   assign mag_sum  = {1'b0, sr_ff} + {1'b0, si_ff};
   assign sr_shift = sr_ff >> FRAC_BITS;
   assign si_shift = si_ff >> FRAC_BITS;
   assign xp_shift = xp_ff >> (FRAC_BITS - 1);
   assign cr_ext   = {{(Z_W-C_W){cr_ff[C_W-1]}}, cr_ff};
   assign ci_ext   = {{(Z_W-C_W){ci_ff[C_W-1]}}, ci_ff};
   assign cross_term = (zr_ff[Z_W-1] != zi_ff[Z_W-1]) ? (Z_W'(0) - xp_shift[Z_W-1:0])
                                                      : xp_shift[Z_W-1:0];
   assign nr       = sr_shift[Z_W-1:0] - si_shift[Z_W-1:0] + cr_ext;
   assign ni       = cross_term + ci_ext;
   assign part_shifted = ACC_W'(prod_ff) << (LIMB_W * prod_sh_ff);

   always_comb begin
      state_in      = state_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      cr_in         = cr_ff;
      ci_in         = ci_ff;
      zr_in         = zr_ff;
      zi_in         = zi_ff;
      n_in          = n_ff;
      ar_in         = ar_ff;
      ai_in         = ai_ff;
      sr_in         = sr_ff;
      si_in         = si_ff;
      xp_in         = xp_ff;
      pair_in       = pair_ff;
      psel_in       = psel_ff;
      prod_vld_in   = 1'b0;
      prod_tag_in   = psel_ff;
      prod_sh_in    = SH_W'(lim_i) + SH_W'(lim_j);
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_count_in  = rsp_count_ff;
      rsp_inside_in = rsp_inside_ff;

      // Fold the registered partial product into its accumulator
      if (prod_vld_ff) begin
         unique case (prod_tag_ff)
            PROD_RR: sr_in = sr_ff + part_shifted;
            PROD_II: si_in = si_ff + part_shifted;
            default: xp_in = xp_ff + part_shifted;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // clamp pixels that fall outside the frame
               px_in = (PIX_CMP_W'(req_pixel_x) >= PIX_CMP_W'(FRAME_WIDTH)) ? X_LAST
                                                                            : req_pixel_x;
               py_in = (PIX_CMP_W'(req_pixel_y) >= PIX_CMP_W'(FRAME_HEIGHT)) ? Y_LAST
                                                                             : req_pixel_y;
               state_in = ST_CR;
            end
         end
         ST_CR: begin
            state_in = ST_CI;
         end
         ST_CI: begin
            cr_in = {{(C_W-COORD_W){origin_real_ff[COORD_W-1]}}, origin_real_ff}
                  + {{(C_W-PXS_W){1'b0}}, prod_ff[PXS_W-1:0]};
            state_in = ST_CINIT;
         end
         ST_CINIT: begin
            ci_in = {{(C_W-COORD_W){origin_imag_ff[COORD_W-1]}}, origin_imag_ff}
                  + {{(C_W-PXS_W){1'b0}}, prod_ff[PXS_W-1:0]};
            zr_in    = '0;
            zi_in    = '0;
            n_in     = '0;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (n_ff == max_iter_ff) begin
               state_in = ST_OUT;
            end else if (mag_r > EDGE || mag_i > EDGE) begin
               state_in = ST_OUT;
            end else begin
               ar_in    = mag_r[OPW-1:0];
               ai_in    = mag_i[OPW-1:0];
               sr_in    = '0;
               si_in    = '0;
               xp_in    = '0;
               pair_in  = '0;
               psel_in  = PROD_RR;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_vld_in = 1'b1;
            if (pair_ff == PAIR_W'(PAIRS - 1)) begin
               pair_in = '0;
               if (psel_ff == PROD_RI) begin
                  state_in = ST_WAIT;
               end else begin
                  psel_in = psel_ff + prod_sel_type'(1);
               end
            end else begin
               pair_in = pair_ff + PAIR_W'(1);
            end
         end
         ST_WAIT: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (mag_sum > LIMIT) begin
               state_in = ST_OUT;
            end else begin
               zr_in    = nr;
               zi_in    = ni;
               n_in     = n_ff + COUNT_W'(1);
               state_in = ST_CHECK;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = n_ff;
               rsp_inside_in = (n_ff == max_iter_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         prod_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         origin_real_ff <= ORIGIN_REAL_RST;
         origin_imag_ff <= ORIGIN_IMAG_RST;
         step_real_ff   <= STEP_REAL_RST;
         step_imag_ff   <= STEP_IMAG_RST;
         max_iter_ff    <= MAX_ITER_RST;
      end else begin
         state_ff     <= state_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_ORIGIN_REAL: origin_real_ff <= csr_wdata[COORD_W-1:0];
               CSR_ORIGIN_IMAG: origin_imag_ff <= csr_wdata[COORD_W-1:0];
               CSR_STEP_REAL:   step_real_ff   <= csr_wdata[STEP_W-1:0];
               CSR_STEP_IMAG:   step_imag_ff   <= csr_wdata[STEP_W-1:0];
               CSR_MAX_ITER:    max_iter_ff    <= csr_wdata[COUNT_W-1:0];
               default: ;   // drop writes to unknown indexes
            endcase
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      px_ff         <= px_in;
      py_ff         <= py_in;
      cr_ff         <= cr_in;
      ci_ff         <= ci_in;
      zr_ff         <= zr_in;
      zi_ff         <= zi_in;
      n_ff          <= n_in;
      ar_ff         <= ar_in;
      ai_ff         <= ai_in;
      sr_ff         <= sr_in;
      si_ff         <= si_in;
      xp_ff         <= xp_in;
      pair_ff       <= pair_in;
      psel_ff       <= psel_in;
      prod_ff       <= mul_p;
      prod_tag_ff   <= prod_tag_in;
      prod_sh_ff    <= prod_sh_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_inside_ff <= rsp_inside_in;
   end

`ifndef SYNTHESIS
   // A new response only ever comes from the hand-over state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response raised outside hand-over state");

   // The count never runs past the limit while iterating
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK || state_ff == ST_MUL || state_ff == ST_WAIT ||
       state_ff == ST_EVAL) |-> n_ff <= max_iter_ff)
      else $error("iteration count beyond limit");

   // Partial products are only in flight during the multiply phase
   a_prod_phase: assert property (@(posedge clock) disable iff (reset)
      prod_vld_ff |-> (state_ff == ST_MUL || state_ff == ST_WAIT))
      else $error("partial product outside multiply phase");

   // Inside flag only with a count at the limit
   a_inside_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_inside_ff) |-> rsp_count_ff == max_iter_ff)
      else $error("inside flag without count at limit");
`endif

endmodule

`default_nettype wire
